// ===== hdl/h2r_pkg.sv =====
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared widths, fixed-point constants and lookup tables for the HSL to RGB
// converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int FRAC_BITS = 16;

  localparam int HUE_W    = 9;
  localparam int PCT_W    = 7;
  localparam int CHAN_W   = 8;
  localparam int SEG_W    = 3;
  localparam int REM_W    = 6;
  localparam int TDATA_W  = 24;
  localparam int PCT_MAX  = 100;

  localparam int HUE_SEG_DEG = 45;
  localparam int HUE_SEGS    = 8;

  typedef logic [FRAC_BITS:0]   fx_t;
  typedef logic [FRAC_BITS-1:0] hk_t;
  typedef logic [FRAC_BITS-4:0] hfrac_t;

  localparam logic [HUE_W-1:0] HUE_TURN = HUE_W'(360);

  localparam fx_t FX_ONE        = fx_t'(64'd1 << FRAC_BITS);
  localparam fx_t FX_THIRD      = fx_t'((64'd1 << FRAC_BITS) / 3);
  localparam fx_t FX_TWO_THIRDS = fx_t'((64'd2 << FRAC_BITS) / 3);

  typedef enum logic [1:0] {
    RAMP_UP,
    RAMP_TOP,
    RAMP_DOWN,
    RAMP_LOW
  } ramp_e;

  typedef struct packed {
    logic ld_shape;
    logic ld_mul;
    logic ld_out;
  } chan_adv_t;

  typedef fx_t    pct_lut_t [2**PCT_W];
  typedef hfrac_t hue_lut_t [2**REM_W];

  function automatic pct_lut_t build_pct_lut();
    pct_lut_t lut;
    longint   v;
    for (int i = 0; i < 2**PCT_W; i++) begin
      v = (i > PCT_MAX) ? longint'(PCT_MAX) : longint'(i);
      lut[i] = fx_t'((v << FRAC_BITS) / PCT_MAX);
    end
    return lut;
  endfunction

  function automatic hue_lut_t build_hue_lut();
    hue_lut_t lut;
    for (int i = 0; i < 2**REM_W; i++) begin
      if (i < HUE_SEG_DEG) begin
        lut[i] = hfrac_t'((longint'(i) << (FRAC_BITS - SEG_W)) / HUE_SEG_DEG);
      end else begin
        lut[i] = '0;
      end
    end
    return lut;
  endfunction

  localparam pct_lut_t PCT_LUT = build_pct_lut();
  localparam hue_lut_t HUE_LUT = build_hue_lut();

endpackage

// ===== hdl/hsl_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Converts one HSL pixel (degrees, percent, percent) into one 8-bit RGB
// pixel with the piecewise q/p formula in unsigned fixed point.
//
//   channel   dir   tdata fields (low bit up)
//   s_axis    in    hue_deg[8:0] sat_pct[15:9] lum_pct[22:16] zero[23]
//   m_axis    out   red[7:0] green[15:8] blue[23:16]
//
// One pixel per clock while the output is not stalled; six register stages.
// The depth is set by the lookup, l*s product, q/p, ramp select, ramp
// product and scaling stages.
// Reset clears the stage valid bits only.
// A stalled stage holds; a stage takes new data when empty or when the
// stage after it moves, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter
  import h2r_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // hue_deg, sat_pct, lum_pct
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata    // red, green, blue
);

  localparam int NSTG = 6;
  localparam int WLS  = 2 * FRAC_BITS + 2;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [REM_W-1:0] rem;
    fx_t              s;
    fx_t              l;
    logic             grey;
  } s1_t;

  typedef struct packed {
    hk_t  hk;
    fx_t  ls;
    fx_t  s;
    fx_t  l;
    logic grey;
  } s2_t;

  typedef struct packed {
    fx_t [2:0] t;
    fx_t       p;
    fx_t       q;
    logic      grey;
  } s3_t;

  logic [NSTG-1:0] vld_d, vld_q;
  logic [NSTG-1:0] rdy;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;

  logic [HUE_W-1:0] hue_in, hue_w;
  logic [PCT_W-1:0] sat_in, lum_in;
  logic [SEG_W-1:0] seg;
  logic [WLS-1:0]   ls_full;

  logic [FRAC_BITS+1:0]     q_sum;
  fx_t                      q;
  logic signed [FRAC_BITS+2:0] p_s;
  fx_t                      hk_x, t_r, t_b;

  chan_adv_t adv;
  logic [CHAN_W-1:0] red_c, green_c, blue_c;

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    hue_in = s_axis_tdata[HUE_W-1:0];
    sat_in = s_axis_tdata[HUE_W+PCT_W-1:HUE_W];
    lum_in = s_axis_tdata[HUE_W+2*PCT_W-1:HUE_W+PCT_W];
    hue_w = (hue_in >= HUE_TURN) ? hue_in - HUE_TURN : hue_in;
    seg = '0;
    for (int k = 1; k < HUE_SEGS; k++) begin
      if (hue_w >= HUE_W'(k * HUE_SEG_DEG)) begin
        seg = SEG_W'(k);
      end
    end
    s1_d.seg = seg;
    s1_d.rem = REM_W'(hue_w - HUE_W'(seg) * HUE_W'(HUE_SEG_DEG));
    s1_d.s = PCT_LUT[sat_in];
    s1_d.l = PCT_LUT[lum_in];
    s1_d.grey = (sat_in == '0);
  end

  always_comb begin
    ls_full = WLS'(s1_q.l) * WLS'(s1_q.s);
    s2_d.hk = {s1_q.seg, HUE_LUT[s1_q.rem]};
    s2_d.ls = ls_full[2*FRAC_BITS:FRAC_BITS];
    s2_d.s = s1_q.s;
    s2_d.l = s1_q.l;
    s2_d.grey = s1_q.grey;
  end

  always_comb begin
    if ({s2_q.l, 1'b0} < {1'b0, FX_ONE}) begin
      q_sum = (FRAC_BITS+2)'(s2_q.l) + (FRAC_BITS+2)'(s2_q.ls);
    end else begin
      q_sum = (FRAC_BITS+2)'(s2_q.l) + (FRAC_BITS+2)'(s2_q.s)
            - (FRAC_BITS+2)'(s2_q.ls);
    end
    q = q_sum[FRAC_BITS:0];
    p_s = $signed({1'b0, s2_q.l, 1'b0}) - $signed({2'b0, q});
    hk_x = fx_t'(s2_q.hk);
    t_r = hk_x + FX_THIRD;
    if (t_r > FX_ONE) begin
      t_r = t_r - FX_ONE;
    end
    t_b = (hk_x < FX_THIRD) ? hk_x + FX_ONE - FX_THIRD : hk_x - FX_THIRD;
    s3_d.t[0] = t_r;
    s3_d.t[1] = hk_x;
    s3_d.t[2] = t_b;
    s3_d.q = q;
    if (s2_q.grey) begin
      s3_d.p = s2_q.l;
    end else if (p_s[FRAC_BITS+2]) begin
      s3_d.p = '0;
    end else begin
      s3_d.p = p_s[FRAC_BITS:0];
    end
    s3_d.grey = s2_q.grey;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid) begin
      s1_q <= s1_d;
    end
    if (rdy[1] && vld_q[0]) begin
      s2_q <= s2_d;
    end
    if (rdy[2] && vld_q[1]) begin
      s3_q <= s3_d;
    end
  end

  always_comb begin
    adv.ld_shape = rdy[3] && vld_q[2];
    adv.ld_mul = rdy[4] && vld_q[3];
    adv.ld_out = rdy[5] && vld_q[4];
  end

  h2r_chan u_red (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .grey_i (s3_q.grey),
    .p_i    (s3_q.p),
    .q_i    (s3_q.q),
    .t_i    (s3_q.t[0]),
    .chan_o (red_c)
  );

  h2r_chan u_green (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .grey_i (s3_q.grey),
    .p_i    (s3_q.p),
    .q_i    (s3_q.q),
    .t_i    (s3_q.t[1]),
    .chan_o (green_c)
  );

  h2r_chan u_blue (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .grey_i (s3_q.grey),
    .p_i    (s3_q.p),
    .q_i    (s3_q.q),
    .t_i    (s3_q.t[2]),
    .chan_o (blue_c)
  );

  assign m_axis_tdata = {blue_c, green_c, red_c};

  a_accept_fills_first: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0]
  ) else $error("accepted request did not enter the first stage");

  a_qp_order: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && !s3_q.grey |-> s3_q.q >= s3_q.p && s3_q.q <= FX_ONE
  ) else $error("q/p terms out of order or above one");

  a_stage3_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && !rdy[2] |=> vld_q[2] && $stable(s3_q)
  ) else $error("stalled stage three lost or changed its request");

endmodule

// ===== hdl/h2r_chan.sv =====
// ----------------------------------------------------------------------------
// h2r_chan
// One color channel: ramp selection, ramp product, level pick and scaling
// to an 8-bit value, over three register stages.
// ----------------------------------------------------------------------------
module h2r_chan
  import h2r_pkg::*;
(
  input  logic              clk_i,
  input  chan_adv_t         adv_i,
  input  logic              grey_i,
  input  fx_t               p_i,
  input  fx_t               q_i,
  input  fx_t               t_i,
  output logic [CHAN_W-1:0] chan_o
);

  localparam int W6 = FRAC_BITS + 4;
  localparam int WP = 2 * FRAC_BITS + 2;
  localparam int WL = FRAC_BITS + 2;
  localparam int WS = WL + CHAN_W;

  typedef struct packed {
    ramp_e shape;
    fx_t   d;
    fx_t   m;
    fx_t   p;
    fx_t   q;
  } shape_t;

  typedef struct packed {
    ramp_e shape;
    fx_t   prod;
    fx_t   p;
    fx_t   q;
  } mul_t;

  shape_t            sh_d, sh_q;
  mul_t              mu_d, mu_q;
  logic [CHAN_W-1:0] out_d, out_q;

  logic [W6-1:0]        t6, r6;
  logic [W6-1:0]        t2, t3;
  logic signed [WL-1:0] r_s;
  fx_t                  r;
  logic [WP-1:0]        prod_full;
  logic [WL-1:0]        level;
  logic [WS-1:0]        scaled;
  logic [WS-FRAC_BITS-1:0] chan_w;

  always_comb begin
    t6 = (W6'(t_i) << 2) + (W6'(t_i) << 1);
    t2 = W6'(t_i) << 1;
    t3 = W6'(t_i) + (W6'(t_i) << 1);
    r_s = $signed({1'b0, FX_TWO_THIRDS}) - $signed({1'b0, t_i});
    r = r_s[WL-1] ? '0 : r_s[FRAC_BITS:0];
    r6 = (W6'(r) << 2) + (W6'(r) << 1);
    sh_d.d = q_i - p_i;
    sh_d.p = p_i;
    sh_d.q = q_i;
    sh_d.m = '0;
    if (grey_i) begin
      sh_d.shape = RAMP_LOW;
    end else if (t6 < W6'(FX_ONE)) begin
      sh_d.shape = RAMP_UP;
      sh_d.m = t6[FRAC_BITS:0];
    end else if (t2 < W6'(FX_ONE)) begin
      sh_d.shape = RAMP_TOP;
    end else if (t3 < (W6'(FX_ONE) << 1)) begin
      sh_d.shape = RAMP_DOWN;
      sh_d.m = r6[FRAC_BITS:0];
    end else begin
      sh_d.shape = RAMP_LOW;
    end
  end

  always_comb begin
    prod_full = WP'(sh_q.d) * WP'(sh_q.m);
    mu_d.shape = sh_q.shape;
    mu_d.prod = prod_full[2*FRAC_BITS:FRAC_BITS];
    mu_d.p = sh_q.p;
    mu_d.q = sh_q.q;
  end

  always_comb begin
    case (mu_q.shape)
      RAMP_UP, RAMP_DOWN: level = WL'(mu_q.p) + WL'(mu_q.prod);
      RAMP_TOP:           level = WL'(mu_q.q);
      RAMP_LOW:           level = WL'(mu_q.p);
      default:            level = WL'(mu_q.p);
    endcase
    scaled = (WS'(level) << CHAN_W) - WS'(level);
    chan_w = scaled[WS-1:FRAC_BITS];
    out_d = (chan_w > (WS-FRAC_BITS)'(2**CHAN_W - 1)) ? '1 : chan_w[CHAN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld_shape) begin
      sh_q <= sh_d;
    end
    if (adv_i.ld_mul) begin
      mu_q <= mu_d;
    end
    if (adv_i.ld_out) begin
      out_q <= out_d;
    end
  end

  assign chan_o = out_q;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hsl_to_rgb_converter. A table of directed pixels
// (grey, the range extremes, hue wrap, clamped percentages, primary hues) is
// followed by random pixels under changing source and sink back-pressure.
// Every accepted request gets an expected result, from the table or predicted in
// fixed point, and is compared with the result stream, channel by channel, in order.
// ----------------------------------------------------------------------------
module testbench
  import h2r_pkg::*;
;

  localparam longint FX_UNIT      = longint'(1) << FRAC_BITS;
  localparam int     QUIET_LIMIT  = 2000;
  localparam int     HOLD_CYCLES  = 200;
  localparam int     PHASE_ITEMS  = 250;
  localparam int     DIRECTED_ROWS = 22;

  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [PCT_W-1:0]   sat;
    logic [PCT_W-1:0]   lum;
    logic               known;
    logic [TDATA_W-1:0] rgb;
  } pixel_row_t;

  localparam pixel_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{9'd0,   7'd0,   7'd0,   1'b1, 24'h000000},
    '{9'd0,   7'd0,   7'd100, 1'b1, 24'hFFFFFF},
    '{9'd200, 7'd0,   7'd127, 1'b1, 24'hFFFFFF},
    '{9'd511, 7'd127, 7'd127, 1'b1, 24'hFFFFFF},
    '{9'd0,   7'd127, 7'd0,   1'b1, 24'h000000},
    '{9'd0,   7'd100, 7'd50,  1'b1, 24'h0000FF},
    '{9'd360, 7'd100, 7'd50,  1'b1, 24'h0000FF},
    '{9'd361, 7'd100, 7'd50,  1'b0, 24'h000000},
    '{9'd60,  7'd100, 7'd50,  1'b0, 24'h000000},
    '{9'd120, 7'd100, 7'd50,  1'b0, 24'h000000},
    '{9'd180, 7'd100, 7'd50,  1'b0, 24'h000000},
    '{9'd240, 7'd100, 7'd50,  1'b0, 24'h000000},
    '{9'd300, 7'd100, 7'd50,  1'b0, 24'h000000},
    '{9'd359, 7'd100, 7'd50,  1'b0, 24'h000000},
    '{9'd45,  7'd50,  7'd25,  1'b0, 24'h000000},
    '{9'd90,  7'd1,   7'd99,  1'b0, 24'h000000},
    '{9'd270, 7'd99,  7'd1,   1'b0, 24'h000000},
    '{9'd30,  7'd100, 7'd49,  1'b0, 24'h000000},
    '{9'd150, 7'd100, 7'd51,  1'b0, 24'h000000},
    '{9'd330, 7'd64,  7'd75,  1'b0, 24'h000000},
    '{9'd256, 7'd42,  7'd33,  1'b0, 24'h000000},
    '{9'd100, 7'd101, 7'd60,  1'b0, 24'h000000}
  };

  localparam int SEND_IDLE [4] = '{0, 77, 0, 11};
  localparam int SINK_STALL [4] = '{0, 0, 77, 11};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;   // hue_deg, sat_pct, lum_pct, zero
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // red, green, blue

  logic [TDATA_W-1:0] pending_rgb [$];
  logic [TDATA_W-1:0] want_rgb;
  int                 mismatch_count = 0;
  int                 quiet_cycles = 0;
  int                 send_idle_pct = 0;
  int                 sink_stall_pct = 0;
  int                 hold_left = 0;

  hsl_to_rgb_converter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint ramp_level(longint t, longint p, longint q);
    longint d;
    longint r;
    d = q - p;
    if (t < 0) t = t + FX_UNIT;
    if (t > FX_UNIT) t = t - FX_UNIT;
    if (t < 0) t = 0;
    if (d < 0) d = 0;
    if (t * 6 < FX_UNIT) return p + ((d * 6 * t) >>> FRAC_BITS);
    if (t * 2 < FX_UNIT) return q;
    if (t * 3 < 2 * FX_UNIT) begin
      r = (2 * FX_UNIT) / 3 - t;
      if (r < 0) r = 0;
      return p + ((d * 6 * r) >>> FRAC_BITS);
    end
    return p;
  endfunction

  function automatic logic [CHAN_W-1:0] level_to_chan(longint v);
    longint c;
    if (v <= 0) return '0;
    c = (v * 255) >>> FRAC_BITS;
    return (c > 255) ? CHAN_W'(255) : CHAN_W'(c);
  endfunction

  function automatic logic [TDATA_W-1:0] hsl_to_rgb(logic [HUE_W-1:0] hue_deg,
                                                   logic [PCT_W-1:0] sat_pct,
                                                   logic [PCT_W-1:0] lum_pct);
    longint             hue, sat, lum, s, l, ls, q, p, hk, third;
    logic [CHAN_W-1:0]  grey;
    hue = hue_deg;
    sat = sat_pct;
    lum = lum_pct;
    if (hue >= 360) hue = hue - 360;
    if (sat > 100) sat = 100;
    if (lum > 100) lum = 100;
    s = (sat * FX_UNIT) / 100;
    l = (lum * FX_UNIT) / 100;
    if (sat == 0) begin
      grey = level_to_chan(l);
      return {grey, grey, grey};
    end
    ls = (l * s) >>> FRAC_BITS;
    q = (2 * l < FX_UNIT) ? l + ls : l + s - ls;
    p = 2 * l - q;
    if (p < 0) p = 0;
    hk = (hue * FX_UNIT) / 360;
    third = FX_UNIT / 3;
    return {level_to_chan(ramp_level(hk - third, p, q)),
            level_to_chan(ramp_level(hk, p, q)),
            level_to_chan(ramp_level(hk + third, p, q))};
  endfunction

  task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                            input logic [PCT_W-1:0] lum, input logic known,
                            input logic [TDATA_W-1:0] rgb);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {1'b0, lum, sat, hue};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_rgb.push_back(known ? rgb : hsl_to_rgb(hue, sat, lum));
  endtask

  task automatic send_random_pixel();
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] lum;
    hue = ($urandom_range(0, 9) == 0) ? HUE_W'($urandom_range(360, 511))
                                      : HUE_W'($urandom_range(0, 359));
    case ($urandom_range(0, 9))
      0:       sat = '0;
      1:       sat = PCT_W'($urandom_range(101, 127));
      default: sat = PCT_W'($urandom_range(1, 100));
    endcase
    lum = ($urandom_range(0, 9) == 0) ? PCT_W'($urandom_range(101, 127))
                                      : PCT_W'($urandom_range(0, 100));
    send_pixel(hue, sat, lum, 1'b0, '0);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_rgb.size() == 0) begin
        $error("unexpected result: rgb %06h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want_rgb = pending_rgb.pop_front();
        if (m_axis_tdata[7:0] !== want_rgb[7:0]) begin
          $error("red: expected %0d, got %0d", want_rgb[7:0], m_axis_tdata[7:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[15:8] !== want_rgb[15:8]) begin
          $error("green: expected %0d, got %0d", want_rgb[15:8], m_axis_tdata[15:8]);
          mismatch_count++;
        end
        if (m_axis_tdata[23:16] !== want_rgb[23:16]) begin
          $error("blue: expected %0d, got %0d", want_rgb[23:16], m_axis_tdata[23:16]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("hsl_to_rgb_converter verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_pixel(DIRECTED[i].hue, DIRECTED[i].sat, DIRECTED[i].lum,
                 DIRECTED[i].known, DIRECTED[i].rgb);
    end
    wait_drained();

    // hold the sink off while the source keeps pushing, then drain fully
    hold_left = HOLD_CYCLES;
    repeat (40) send_random_pixel();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      sink_stall_pct = SINK_STALL[ph];
      repeat (PHASE_ITEMS) send_random_pixel();
    end
    sink_stall_pct = 0;
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("hsl_to_rgb_converter verification clean");
    end else begin
      $display("hsl_to_rgb_converter verification failed");
    end
    $finish;
  end

endmodule
